// ===== rtl/wiki_markup_zone_splitter_top_assert.svh =====
// Assertion macros for the zone splitter checker.
// Depends on nothing; included by the checker file.
`ifndef WIKI_MARKUP_ZONE_SPLITTER_TOP_ASSERT_SVH
`define WIKI_MARKUP_ZONE_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WMZS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WMZS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wmzs_pkg.sv =====
// Shared types and constants of the wiki markup zone splitter.
// No dependencies; imported by the head logic, output buffer and top level.
package wmzs_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        ZONE_BODY = 2'd0,
        ZONE_INFO = 2'd1,
        ZONE_CAT  = 2'd2,
        ZONE_EXT  = 2'd3
    } zone_t;

    localparam int LEN_INFO = 9;
    localparam int LEN_CAT  = 10;
    localparam int LEN_EXT  = 20;
    localparam int SKIP_W   = 5;

    // String constants: the first character sits in the top byte.
    localparam logic [8*LEN_INFO-1:0] PAT_INFO = "{{infobox";
    localparam logic [8*LEN_CAT-1:0]  PAT_CAT  = "[[category";
    localparam logic [8*LEN_EXT-1:0]  PAT_EXT  = "== external links ==";

    localparam byte_t CH_LBRACE = 8'h7B;
    localparam byte_t CH_RBRACE = 8'h7D;
    localparam byte_t CH_RBRACK = 8'h5D;

    typedef struct packed {
        logic  emit;
        zone_t zone;
        byte_t data;
    } head_res_t;

    typedef struct packed {
        logic  unbalanced;
        logic  is_last;
        zone_t zone;
        byte_t data;
    } result_t;

endpackage

// ===== rtl/wmzs_head.sv =====
// Head-of-window decision: marker matching, zone tracking and brace counting.
// Depends on wmzs_pkg; instantiated by the top level.
module wmzs_head
    import wmzs_pkg::*;
#(
    parameter int WINDOW_BYTES = 20,
    parameter int MAX_NEST     = 255,
    parameter int FW           = $clog2(WINDOW_BYTES + 1),
    parameter int DW           = $clog2(MAX_NEST + 1)
)
(
    input  byte_t             win [WINDOW_BYTES],
    input  logic [FW-1:0]     fill,
    input  zone_t             mode,
    input  logic [DW-1:0]     depth,
    input  logic [SKIP_W-1:0] skip,
    input  byte_t             prev,
    output head_res_t         res,
    output zone_t             mode_next,
    output logic [DW-1:0]     depth_next,
    output logic [SKIP_W-1:0] skip_next
);

    logic  m_info;
    logic  m_cat;
    logic  m_ext;
    zone_t eff_mode;
    logic [DW-1:0] depth_dec;

    always_comb
    begin
        m_info = (fill >= FW'(LEN_INFO));
        for (int k = 0; k < LEN_INFO; k++)
        begin
            if (win[k] != PAT_INFO[8*(LEN_INFO-1-k) +: 8])
            begin
                m_info = 1'b0;
            end
        end
        m_cat = (fill >= FW'(LEN_CAT));
        for (int k = 0; k < LEN_CAT; k++)
        begin
            if (win[k] != PAT_CAT[8*(LEN_CAT-1-k) +: 8])
            begin
                m_cat = 1'b0;
            end
        end
        m_ext = (fill >= FW'(LEN_EXT));
        for (int k = 0; k < LEN_EXT; k++)
        begin
            if (win[k] != PAT_EXT[8*(LEN_EXT-1-k) +: 8])
            begin
                m_ext = 1'b0;
            end
        end
    end

    always_comb
    begin
        res.emit   = 1'b0;
        res.zone   = ZONE_BODY;
        res.data   = win[0];
        mode_next  = mode;
        depth_next = depth;
        skip_next  = skip;
        eff_mode   = mode;
        depth_dec  = (depth != '0) ? depth - DW'(1) : depth;
        if (skip != '0)
        begin
            skip_next = skip - SKIP_W'(1);
        end
        else
        begin
            // A category marker ends the external-links zone.
            if (mode == ZONE_EXT && m_cat)
            begin
                eff_mode = ZONE_BODY;
            end
            mode_next = eff_mode;
            unique case (eff_mode)
                ZONE_BODY:
                begin
                    if (m_info)
                    begin
                        mode_next  = ZONE_INFO;
                        depth_next = DW'(1);
                        skip_next  = SKIP_W'(LEN_INFO - 1);
                    end
                    else if (m_cat)
                    begin
                        mode_next = ZONE_CAT;
                        skip_next = SKIP_W'(LEN_CAT - 1);
                    end
                    else if (m_ext)
                    begin
                        mode_next = ZONE_EXT;
                        skip_next = SKIP_W'(LEN_EXT - 1);
                    end
                    else
                    begin
                        res.emit = 1'b1;
                        res.zone = ZONE_BODY;
                    end
                end
                ZONE_INFO:
                begin
                    res.emit = 1'b1;
                    res.zone = ZONE_INFO;
                    if (prev == CH_LBRACE && win[0] == CH_LBRACE)
                    begin
                        if (depth < DW'(MAX_NEST))
                        begin
                            depth_next = depth + DW'(1);
                        end
                    end
                    else if (prev == CH_RBRACE && win[0] == CH_RBRACE)
                    begin
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                        begin
                            mode_next = ZONE_BODY;
                        end
                    end
                end
                ZONE_CAT:
                begin
                    res.emit = 1'b1;
                    res.zone = ZONE_CAT;
                    if (prev == CH_RBRACK && win[0] == CH_RBRACK)
                    begin
                        mode_next = ZONE_BODY;
                    end
                end
                ZONE_EXT:
                begin
                    res.emit = 1'b1;
                    res.zone = ZONE_EXT;
                end
                default:
                begin
                    res.emit = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/wmzs_ofifo.sv =====
// Output register with one skid entry for the result stream.
// Depends on wmzs_pkg; instantiated by the top level.
module wmzs_ofifo
    import wmzs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    room,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg)
        begin
            if (push)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next = skid_data_reg;
                if (push)
                begin
                    skid_data_next = push_data;
                end
                else
                begin
                    skid_valid_next = 1'b0;
                end
            end
            else if (push)
            begin
                out_data_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== rtl/wiki_markup_zone_splitter_top.sv =====
// Top level of the wiki markup zone splitter: lookahead window, page flush control.
// Depends on wmzs_pkg, wmzs_head and wmzs_ofifo.
//
//  Channel  Direction  Carries
//  s_*      in         tdata[7:0] in_byte, tlast page_end
//  m_*      out        tdata[7:0] out_byte, tuser[1:0] zone, tuser[2] unbalanced,
//                      tlast is_last
//
// One input word per cycle while a page streams and the output has room; a byte leaves
// WINDOW_BYTES - 1 words after it entered and then passes through the output register.
// A word with tlast starts a flush of the window: s_tready stays low while the bytes held
// (up to WINDOW_BYTES) drain and the final word is pushed.
// A stall on m_tready backs up through the one-entry skid buffer into s_tready.
// Reset clears the window fill count, zone state and output valid flags.
module wiki_markup_zone_splitter_top
    import wmzs_pkg::*;
#(
    parameter int WINDOW_BYTES = 20,
    parameter int MAX_NEST     = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [1:0] zone, [2] unbalanced
    output logic       m_tlast
);

    localparam int FW = $clog2(WINDOW_BYTES + 1);
    localparam int DW = $clog2(MAX_NEST + 1);

    typedef enum logic [2:0] {
        ST_RUN    = 3'b001,
        ST_DRAIN  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    byte_t             win_reg [WINDOW_BYTES];
    byte_t             win_next [WINDOW_BYTES];
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     fill_next;
    zone_t             mode_reg;
    zone_t             mode_next;
    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     depth_next;
    logic [SKIP_W-1:0] skip_reg;
    logic [SKIP_W-1:0] skip_next;
    byte_t             prev_reg;
    byte_t             prev_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    head_res_t         pend_reg;
    head_res_t         pend_next;

    byte_t             in_lc;
    byte_t             cw [WINDOW_BYTES];
    byte_t             hwin [WINDOW_BYTES];
    byte_t             sh [WINDOW_BYTES];
    logic [FW-1:0]     fill_inc;
    logic [FW-1:0]     hfill;
    head_res_t         hres;
    zone_t             h_mode;
    logic [DW-1:0]     h_depth;
    logic [SKIP_W-1:0] h_skip;
    logic              accept;
    logic              room;
    logic              push;
    result_t           push_data;
    result_t           out_data;

    assign in_lc    = (s_tdata >= 8'h41 && s_tdata <= 8'h5A) ? s_tdata + 8'h20 : s_tdata;
    assign fill_inc = fill_reg + FW'(1);
    assign s_tready = (state_reg == ST_RUN) && room;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int k = 0; k < WINDOW_BYTES; k++)
        begin
            cw[k] = (FW'(k) == fill_reg) ? in_lc : win_reg[k];
        end
        for (int k = 0; k < WINDOW_BYTES; k++)
        begin
            hwin[k] = (state_reg == ST_DRAIN) ? win_reg[k] : cw[k];
        end
        for (int k = 0; k < WINDOW_BYTES - 1; k++)
        begin
            sh[k] = hwin[k+1];
        end
        sh[WINDOW_BYTES-1] = hwin[WINDOW_BYTES-1];
        hfill = (state_reg == ST_DRAIN) ? fill_reg : fill_inc;
    end

    wmzs_head #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .MAX_NEST     (MAX_NEST),
        .FW           (FW),
        .DW           (DW)
    ) u_head (
        .win        (hwin),
        .fill       (hfill),
        .mode       (mode_reg),
        .depth      (depth_reg),
        .skip       (skip_reg),
        .prev       (prev_reg),
        .res        (hres),
        .mode_next  (h_mode),
        .depth_next (h_depth),
        .skip_next  (h_skip)
    );

    always_comb
    begin
        state_next      = state_reg;
        win_next        = win_reg;
        fill_next       = fill_reg;
        mode_next       = mode_reg;
        depth_next      = depth_reg;
        skip_next       = skip_reg;
        prev_next       = prev_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_data       = '{unbalanced: 1'b0, is_last: 1'b0, zone: hres.zone, data: hres.data};
        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (s_tlast)
                    begin
                        win_next   = cw;
                        fill_next  = fill_inc;
                        state_next = ST_DRAIN;
                    end
                    else if (fill_inc == FW'(WINDOW_BYTES))
                    begin
                        win_next   = sh;
                        mode_next  = h_mode;
                        depth_next = h_depth;
                        skip_next  = h_skip;
                        prev_next  = hres.data;
                        push       = hres.emit;
                    end
                    else
                    begin
                        win_next  = cw;
                        fill_next = fill_inc;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (room)
                begin
                    win_next   = sh;
                    fill_next  = fill_reg - FW'(1);
                    mode_next  = h_mode;
                    depth_next = h_depth;
                    skip_next  = h_skip;
                    prev_next  = hres.data;
                    if (hres.emit)
                    begin
                        // The held word goes out once a later one exists.
                        push            = pend_valid_reg;
                        push_data.zone  = pend_reg.zone;
                        push_data.data  = pend_reg.data;
                        pend_valid_next = 1'b1;
                        pend_next       = hres;
                    end
                    if (fill_reg == FW'(1))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (room)
                begin
                    push                 = 1'b1;
                    push_data.is_last    = 1'b1;
                    push_data.unbalanced = (mode_reg == ZONE_INFO);
                    push_data.zone       = pend_valid_reg ? pend_reg.zone : ZONE_BODY;
                    push_data.data       = pend_valid_reg ? pend_reg.data : 8'h00;
                    state_next           = ST_RUN;
                    fill_next            = '0;
                    mode_next            = ZONE_BODY;
                    depth_next           = '0;
                    skip_next            = '0;
                    prev_next            = 8'h00;
                    pend_valid_next      = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            fill_reg       <= '0;
            mode_reg       <= ZONE_BODY;
            depth_reg      <= '0;
            skip_reg       <= '0;
            prev_reg       <= 8'h00;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            mode_reg       <= mode_next;
            depth_reg      <= depth_next;
            skip_reg       <= skip_next;
            prev_reg       <= prev_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        pend_reg <= pend_next;
    end

    wmzs_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .room      (room),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign m_tdata = out_data.data;
    assign m_tuser = {out_data.unbalanced, out_data.zone};
    assign m_tlast = out_data.is_last;

endmodule

// ===== rtl/wmzs_chk.sv =====
// Port-level checker for the zone splitter, bound to the top level.
// Depends on wiki_markup_zone_splitter_top_assert.svh.
`include "wiki_markup_zone_splitter_top_assert.svh"

module wmzs_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    `WMZS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output word changed while stalled")
    `WMZS_ASSERT_NOW(a_unbal_last, clk, rst_n, m_tvalid && m_tuser[2], m_tlast, "unbalanced flag on a word that is not last")
    `WMZS_ASSERT_NEXT(a_flush_stall, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready, "input accepted during page flush")

endmodule

bind wiki_markup_zone_splitter_top wmzs_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/wiki_markup_zone_splitter_top_chk.sv =====
`timescale 1ns / 1ps
// Checker for the wiki markup zone splitter: predicts the output words from the accepted
// input words and compares them in order. Depends on wmzs_pkg.
module wiki_markup_zone_splitter_top_chk
    import wmzs_pkg::*;
#(
    parameter int WINDOW_BYTES = 20,
    parameter int MAX_NEST     = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] out_byte
    input  logic [2:0] m_tuser,   // [1:0] zone, [2] unbalanced
    input  logic       m_tlast,
    output int         mismatches,
    output int         outstanding
);

    byte_t       window [WINDOW_BYTES];
    int unsigned fill;
    int unsigned skip;
    int unsigned depth;
    zone_t       mode;
    byte_t       prev;
    result_t     due_words [$];
    result_t     want_word;
    result_t     seen_word;

    function automatic bit window_holds(input logic [8*LEN_EXT-1:0] pat, input int len);
        if (fill < len)
            return 1'b0;
        for (int k = 0; k < len; k++)
        begin
            if (window[k] != pat[8*(len-1-k) +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_state();
        mode  = ZONE_BODY;
        depth = 0;
        fill  = 0;
        skip  = 0;
        prev  = '0;
        foreach (window[i])
            window[i] = '0;
    endtask

    task automatic retire_head(output bit emit, output result_t res);
        byte_t c;
        c         = window[0];
        emit      = 1'b0;
        res       = '0;
        res.data  = c;
        if (skip > 0)
            skip--;
        else
        begin
            if (mode == ZONE_EXT && window_holds((8*LEN_EXT)'(PAT_CAT), LEN_CAT))
                mode = ZONE_BODY;
            case (mode)
                ZONE_BODY:
                begin
                    if (window_holds((8*LEN_EXT)'(PAT_INFO), LEN_INFO))
                    begin
                        mode  = ZONE_INFO;
                        depth = 1;
                        skip  = LEN_INFO - 1;
                    end
                    else if (window_holds((8*LEN_EXT)'(PAT_CAT), LEN_CAT))
                    begin
                        mode = ZONE_CAT;
                        skip = LEN_CAT - 1;
                    end
                    else if (window_holds(PAT_EXT, LEN_EXT))
                    begin
                        mode = ZONE_EXT;
                        skip = LEN_EXT - 1;
                    end
                    else
                        emit = 1'b1;
                end
                ZONE_INFO:
                begin
                    emit     = 1'b1;
                    res.zone = ZONE_INFO;
                    if (prev == CH_LBRACE && c == CH_LBRACE)
                    begin
                        if (depth < MAX_NEST)
                            depth++;
                    end
                    else if (prev == CH_RBRACE && c == CH_RBRACE)
                    begin
                        if (depth > 0)
                            depth--;
                        if (depth == 0)
                            mode = ZONE_BODY;
                    end
                end
                ZONE_CAT:
                begin
                    emit     = 1'b1;
                    res.zone = ZONE_CAT;
                    if (prev == CH_RBRACK && c == CH_RBRACK)
                        mode = ZONE_BODY;
                end
                default:
                begin
                    emit     = 1'b1;
                    res.zone = ZONE_EXT;
                end
            endcase
        end
        prev = c;
        for (int i = 0; i + 1 < WINDOW_BYTES; i++)
            window[i] = window[i+1];
        if (fill > 0)
            fill--;
    endtask

    task automatic split_word(input byte_t raw, input logic page_end);
        byte_t   b;
        bit      emit;
        result_t res;
        result_t flushed [$];
        b = raw;
        if (b >= "A" && b <= "Z")
            b = b + 8'd32;
        if (fill < WINDOW_BYTES)
        begin
            window[fill] = b;
            fill++;
        end
        if (!page_end)
        begin
            if (fill >= WINDOW_BYTES)
            begin
                retire_head(emit, res);
                if (emit)
                    due_words.push_back(res);
            end
        end
        else
        begin
            while (fill > 0 && flushed.size() < WINDOW_BYTES)
            begin
                retire_head(emit, res);
                if (emit)
                    flushed.push_back(res);
            end
            // A page made only of markers still closes with one empty word.
            if (flushed.size() == 0)
                flushed.push_back('0);
            res            = flushed.pop_back();
            res.is_last    = 1'b1;
            res.unbalanced = (mode == ZONE_INFO);
            flushed.push_back(res);
            foreach (flushed[i])
                due_words.push_back(flushed[i]);
            clear_state();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_state();
            due_words.delete();
            mismatches = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                split_word(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                seen_word = {m_tuser[2], m_tlast, zone_t'(m_tuser[1:0]), m_tdata};
                if (due_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: data %h zone %0d last %b unbalanced %b",
                                 seen_word.data, seen_word.zone, seen_word.is_last,
                                 seen_word.unbalanced);
                end
                else
                begin
                    want_word = due_words.pop_front();
                    if (seen_word.data !== want_word.data || seen_word.zone !== want_word.zone
                        || seen_word.is_last !== want_word.is_last
                        || seen_word.unbalanced !== want_word.unbalanced)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"word mismatch: expected data %h zone %0d last %b ",
                                      "unbalanced %b, got data %h zone %0d last %b unbalanced %b"},
                                     want_word.data, want_word.zone, want_word.is_last,
                                     want_word.unbalanced, seen_word.data, seen_word.zone,
                                     seen_word.is_last, seen_word.unbalanced);
                    end
                end
            end
        end
        outstanding <= due_words.size();
    end

endmodule

// ===== sim/wiki_markup_zone_splitter_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the wiki markup zone splitter: streams pages of marked-up text and
// paces the output side. Depends on wmzs_pkg, the block and wiki_markup_zone_splitter_top_chk.
module wiki_markup_zone_splitter_top_tb;
    import wmzs_pkg::*;

    localparam int WINDOW_BYTES = 20;
    localparam int MAX_NEST     = 255;
    localparam int RANDOM_WORDS = 40;
    localparam int DEEP_RUN     = 6;
    localparam int HOLD_CYCLES  = 200;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic [2:0] m_tuser;   // [1:0] zone, [2] unbalanced
    logic       m_tlast;
    int         mismatches;
    int         outstanding;
    int         gap_pct;
    int         stall_pct;
    int         phase;
    int         words_sent;
    logic       hold_off;
    byte_t      page [$];

    wiki_markup_zone_splitter_top #(
        .WINDOW_BYTES(WINDOW_BYTES),
        .MAX_NEST    (MAX_NEST)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    wiki_markup_zone_splitter_top_chk #(
        .WINDOW_BYTES(WINDOW_BYTES),
        .MAX_NEST    (MAX_NEST)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("** wiki_markup_zone_splitter_top: FAILED **");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= rst_n && !hold_off && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // A long output stall while the sender keeps offering words backs the block up.
    initial
    begin
        hold_off = 1'b0;
        wait (phase == 2);
        repeat (3) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    function automatic void add_text(input string s, input bit mix);
        byte_t c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mix && c >= "a" && c <= "z" && $urandom_range(0, 2) == 0)
                c = c - 8'd32;
            page.push_back(c);
        end
    endfunction

    function automatic void add_noise(input int n);
        string markup = "{}[]= xX";
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0:       page.push_back(byte_t'($urandom_range(0, 255)));
                1:       page.push_back(markup[$urandom_range(0, markup.len() - 1)]);
                default: page.push_back(byte_t'($urandom_range(8'h41, 8'h7A)));
            endcase
        end
    endfunction

    task automatic send_page();
        for (int i = 0; i < page.size(); i++)
        begin
            while ($urandom_range(0, 99) < gap_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= page[i];
            s_tlast  <= (i == page.size() - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
        words_sent += page.size();
        page.delete();
    endtask

    initial
    begin
        int    directed_words;
        int    nseg;
        int    cut;
        string mk;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        words_sent = 0;
        phase      = 0;
        gap_pct    = 11;
        stall_pct  = 66;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        page.push_back(8'h00);
        send_page();
        page.push_back(8'hFF);
        send_page();
        add_text("{{InfoBox", 0);
        send_page();
        add_text("[[Category]]", 0);
        send_page();
        directed_words = words_sent;

        while (words_sent < directed_words + RANDOM_WORDS)
        begin
            phase     = (words_sent - directed_words) * 2 / RANDOM_WORDS;
            gap_pct   = (phase == 0) ? 11 : (phase == 1) ? 66 : 0;
            stall_pct = (phase == 0) ? 66 : (phase == 1) ? 11 : 0;
            nseg      = $urandom_range(1, 2);
            for (int seg = 0; seg < nseg; seg++)
            begin
                add_noise($urandom_range(1, 8));
                case ($urandom_range(0, 4))
                    0:
                    begin
                        add_text("{{infobox", 1);
                        repeat ($urandom_range(0, 5))
                        begin
                            case ($urandom_range(0, 4))
                                0:       add_text("{{", 0);
                                1:       add_text("}}", 0);
                                2:       add_text("{{{", 0);
                                3:       add_text("}}}", 0);
                                default: add_noise($urandom_range(1, 5));
                            endcase
                        end
                        if ($urandom_range(0, 4) != 0)
                            add_text("}}", 0);
                    end
                    1:
                    begin
                        add_text("[[category", 1);
                        add_noise($urandom_range(0, 6));
                        if ($urandom_range(0, 4) != 0)
                            add_text("]]", 0);
                    end
                    2:
                    begin
                        add_text("== external links ==", 1);
                        add_noise($urandom_range(0, 8));
                    end
                    3:
                    begin
                        add_text("== external links ==", 1);
                        add_noise($urandom_range(0, 4));
                        add_text("[[category", 1);
                        add_noise($urandom_range(0, 4));
                        add_text("]]", 0);
                    end
                    default:
                        add_noise($urandom_range(0, 4));
                endcase
            end
            // Sometimes the page stops in the middle of a marker.
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       mk = "{{infobox";
                    1:       mk = "[[category";
                    default: mk = "== external links ==";
                endcase
                cut = $urandom_range(1, mk.len() - 1);
                add_text(mk.substr(0, cut - 1), 1);
            end
            send_page();
        end

        phase     = 2;
        gap_pct   = 0;
        stall_pct = 0;
        add_text("{{infobox", 0);
        repeat (DEEP_RUN) page.push_back(CH_LBRACE);
        add_noise(3);
        repeat (DEEP_RUN) page.push_back(CH_RBRACE);
        add_noise(15);
        send_page();
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (WINDOW_BYTES + 10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("** wiki_markup_zone_splitter_top: PASSED **");
        else
            $display("** wiki_markup_zone_splitter_top: FAILED **");
        $finish;
    end

endmodule

// ===== wiki_markup_zone_splitter_top.f =====
+incdir+rtl
rtl/wmzs_pkg.sv
rtl/wmzs_head.sv
rtl/wmzs_ofifo.sv
rtl/wiki_markup_zone_splitter_top.sv
rtl/wmzs_chk.sv
sim/wiki_markup_zone_splitter_top_chk.sv
sim/wiki_markup_zone_splitter_top_tb.sv
